FILE: rtl/assert_macros.svh
// assertion macros shared by the matcher rtl
// no dependencies; define NO_ASSERTIONS to compile them out
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// checked on every rising edge outside reset
`define NNRM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("nnrm assertion failed");

// checked on every rising edge, reset included
`define NNRM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("nnrm assertion failed");

`else

`define NNRM_ASSERT(label, clk, rst, prop)

`define NNRM_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: rtl/nnrm_pkg.sv
// shared types and constants for the nearest neighbour ratio matcher
// no dependencies
`timescale 1ns / 1ps

package nnrm_pkg;

  // default widths of the stream fields
  localparam int INDEX_BITS_DEF    = 12;
  localparam int DISTANCE_BITS_DEF = 24;
  localparam int COORD_BITS_DEF    = 16;

  // fixed widths of the configuration registers
  localparam int MAX_DIST_W  = 24;
  localparam int RADIUS_W    = 16;
  localparam int RATIO_W     = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  // register reset values
  localparam logic [MAX_DIST_W-1:0] MAX_DIST_RESET = 24'hFFFFFF;
  localparam logic [RADIUS_W-1:0]   RADIUS_RESET   = 16'hFFFF;
  localparam logic [RATIO_W-1:0]    RATIO_RESET    = 16'd52429;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_ENFORCE_MAX_DISTANCE    = 3'd0,
    CFG_MAX_DESCRIPTOR_DISTANCE = 3'd1,
    CFG_GATE_IMAGE_DISTANCE     = 3'd2,
    CFG_MAX_IMAGE_DISTANCE      = 3'd3,
    CFG_USE_RATIO_TEST          = 3'd4,
    CFG_RATIO                   = 3'd5
  } cfg_index_e;

  // gating settings handed to the gate stages
  typedef struct packed {
    logic                  enforce_max;
    logic [MAX_DIST_W-1:0] max_dist;
    logic                  gate_image;
    logic [RADIUS_W-1:0]   max_image;
  } gate_cfg_t;

endpackage

FILE: rtl/nearest_neighbour_ratio_matcher_core.sv
// top level of the nearest neighbour matcher with ratio test
// depends on nnrm_pkg, nnrm_gate, nnrm_out_fifo
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Usage
//   s_axis carries one query-to-candidate pair per transfer; tlast marks the
//   final candidate of a query. m_axis carries at most one match per query,
//   produced only for a transfer with tlast set.
//   cfg_we / cfg_index / cfg_wdata write one setting per cycle; write only
//   while no pair is in flight.
// Timing
//   One pair per cycle while the result buffer has room. A match travels from
//   the input register holding its last pair through two gate stages, the
//   best/second tracker, the ratio multiply stage and the result buffer.
// Reset
//   rst (synchronous) clears the pipeline, the tracker and the result buffer
//   and loads the setting defaults.
// Backpressure
//   Results sit in a two-entry buffer; pairs keep flowing while one result
//   waits. When both entries are full the whole pipeline holds and
//   s_axis_tready drops until the receiver takes a result.
module nearest_neighbour_ratio_matcher_core #(
  parameter int INDEX_BITS    = nnrm_pkg::INDEX_BITS_DEF,
  parameter int DISTANCE_BITS = nnrm_pkg::DISTANCE_BITS_DEF,
  parameter int COORD_BITS    = nnrm_pkg::COORD_BITS_DEF,
  localparam int IN_W  = ((2 * INDEX_BITS + DISTANCE_BITS + 4 * COORD_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((2 * INDEX_BITS + DISTANCE_BITS + 7) / 8) * 8
) (
  input  logic                              clk,
  input  logic                              rst,
  // setting writes
  input  logic                              cfg_we,
  input  logic [nnrm_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [nnrm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // candidate pairs
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // query_index, cand_index, descriptor_distance, query_u, query_v, cand_u, cand_v
  input  logic [IN_W-1:0]                   s_axis_tdata,
  // last
  input  logic                              s_axis_tlast,
  // matches
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // match_query, match_candidate, match_distance
  output logic [OUT_W-1:0]                  m_axis_tdata
);
  import nnrm_pkg::*;

  localparam int OFF_C  = INDEX_BITS;
  localparam int OFF_D  = 2 * INDEX_BITS;
  localparam int OFF_QU = OFF_D + DISTANCE_BITS;
  localparam int OFF_QV = OFF_QU + COORD_BITS;
  localparam int OFF_CU = OFF_QV + COORD_BITS;
  localparam int OFF_CV = OFF_CU + COORD_BITS;
  localparam int PROD_W = DISTANCE_BITS + RATIO_W;

  // settings
  logic                  enforce_max_distance;
  logic [MAX_DIST_W-1:0] max_descriptor_distance;
  logic                  gate_image_distance;
  logic [RADIUS_W-1:0]   max_image_distance;
  logic                  use_ratio_test;
  logic [RATIO_W-1:0]    ratio;
  gate_cfg_t             gate_cfg;

  // pipeline control
  logic adv;
  logic fifo_full;
  logic v0, v1, v2, v3, v4;

  // stage 0: input register
  logic [INDEX_BITS-1:0]    q0, c0;
  logic [DISTANCE_BITS-1:0] d0;
  logic [COORD_BITS-1:0]    qu0, qv0, cu0, cv0;
  logic                     l0;

  // stages 1 and 2: side fields beside the gate
  logic [INDEX_BITS-1:0]    q1, c1, q2, c2;
  logic [DISTANCE_BITS-1:0] d1, d2;
  logic                     l1, l2;
  logic                     pass2;

  // stage 3: tracker state and finished query
  logic [DISTANCE_BITS-1:0] best_distance, best_distance_next;
  logic [INDEX_BITS-1:0]    best_candidate, best_candidate_next;
  logic [DISTANCE_BITS-1:0] second_distance, second_distance_next;
  logic [1:0]               passed_count, passed_count_next;
  logic [DISTANCE_BITS-1:0] best3, second3;
  logic [INDEX_BITS-1:0]    cand3, q3;
  logic [1:0]               cnt3;

  // stage 4: ratio product
  logic [PROD_W-1:0]        prod_next, prod4;
  logic [DISTANCE_BITS-1:0] best4;
  logic [INDEX_BITS-1:0]    cand4, q4;
  logic [1:0]               cnt4;

  // result
  logic             accept;
  logic             push;
  logic [OUT_W-1:0] out_word;

  // the pipeline moves whenever the result buffer has room
  assign adv           = !fifo_full;
  assign s_axis_tready = adv;

  // setting registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enforce_max_distance    <= 1'b0;
      max_descriptor_distance <= MAX_DIST_RESET;
      gate_image_distance     <= 1'b0;
      max_image_distance      <= RADIUS_RESET;
      use_ratio_test          <= 1'b0;
      ratio                   <= RATIO_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index_e'(cfg_index))
        CFG_ENFORCE_MAX_DISTANCE:    enforce_max_distance    <= cfg_wdata[0];
        CFG_MAX_DESCRIPTOR_DISTANCE: max_descriptor_distance <= cfg_wdata[MAX_DIST_W-1:0];
        CFG_GATE_IMAGE_DISTANCE:     gate_image_distance     <= cfg_wdata[0];
        CFG_MAX_IMAGE_DISTANCE:      max_image_distance      <= cfg_wdata[RADIUS_W-1:0];
        CFG_USE_RATIO_TEST:          use_ratio_test          <= cfg_wdata[0];
        CFG_RATIO:                   ratio                   <= cfg_wdata[RATIO_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    gate_cfg.enforce_max = enforce_max_distance;
    gate_cfg.max_dist    = max_descriptor_distance;
    gate_cfg.gate_image  = gate_image_distance;
    gate_cfg.max_image   = max_image_distance;
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (adv) begin
      v0 <= s_axis_tvalid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2 && l2;
      v4 <= v3;
    end
  end

  // input register, loaded on a transfer
  always_ff @(posedge clk) begin
    if (adv && s_axis_tvalid) begin
      q0  <= s_axis_tdata[0 +: INDEX_BITS];
      c0  <= s_axis_tdata[OFF_C +: INDEX_BITS];
      d0  <= s_axis_tdata[OFF_D +: DISTANCE_BITS];
      qu0 <= s_axis_tdata[OFF_QU +: COORD_BITS];
      qv0 <= s_axis_tdata[OFF_QV +: COORD_BITS];
      cu0 <= s_axis_tdata[OFF_CU +: COORD_BITS];
      cv0 <= s_axis_tdata[OFF_CV +: COORD_BITS];
      l0  <= s_axis_tlast;
    end
  end

  // side fields travel alongside the gate stages
  always_ff @(posedge clk) begin
    if (adv) begin
      q1 <= q0;
      c1 <= c0;
      d1 <= d0;
      l1 <= l0;
      q2 <= q1;
      c2 <= c1;
      d2 <= d1;
      l2 <= l1;
    end
  end

  nnrm_gate #(
    .DISTANCE_BITS (DISTANCE_BITS),
    .COORD_BITS    (COORD_BITS)
  ) u_gate (
    .clk       (clk),
    .adv       (adv),
    .pair_dist (d0),
    .query_u   (qu0),
    .query_v   (qv0),
    .cand_u    (cu0),
    .cand_v    (cv0),
    .cfg       (gate_cfg),
    .pass      (pass2)
  );

  // best / second-best update, earlier pair wins ties
  always_comb begin
    best_distance_next   = best_distance;
    best_candidate_next  = best_candidate;
    second_distance_next = second_distance;
    passed_count_next    = passed_count;
    if (pass2) begin
      if (passed_count == 2'd0) begin
        best_distance_next  = d2;
        best_candidate_next = c2;
        passed_count_next   = 2'd1;
      end else begin
        if (d2 < best_distance) begin
          second_distance_next = best_distance;
          best_distance_next   = d2;
          best_candidate_next  = c2;
        end else if (passed_count == 2'd1 || d2 < second_distance) begin
          second_distance_next = d2;
        end
        passed_count_next = 2'd2;
      end
    end
  end

  // tracker state, cleared at the end of each query
  always_ff @(posedge clk) begin
    if (rst) begin
      passed_count <= 2'd0;
    end else if (adv && v2) begin
      if (l2) begin
        passed_count <= 2'd0;
      end else begin
        passed_count <= passed_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && v2) begin
      best_distance   <= best_distance_next;
      best_candidate  <= best_candidate_next;
      second_distance <= second_distance_next;
    end
  end

  // snapshot of the finished query
  always_ff @(posedge clk) begin
    if (adv && v2 && l2) begin
      best3   <= best_distance_next;
      cand3   <= best_candidate_next;
      second3 <= second_distance_next;
      cnt3    <= passed_count_next;
      q3      <= q2;
    end
  end

  // ratio times second-best distance
  assign prod_next = {{DISTANCE_BITS{1'b0}}, ratio} * {{RATIO_W{1'b0}}, second3};

  always_ff @(posedge clk) begin
    if (adv) begin
      prod4 <= prod_next;
      best4 <= best3;
      cand4 <= cand3;
      cnt4  <= cnt3;
      q4    <= q3;
    end
  end

  // accept a lone survivor, or two or more when the ratio test is off or passes
  always_comb begin
    accept = (cnt4 == 2'd1) ||
             ((cnt4 == 2'd2) && (!use_ratio_test || ({best4, {RATIO_W{1'b0}}} < prod4)));
  end

  assign push = adv && v4 && accept;

  // result packing, zero fill above the fields
  always_comb begin
    out_word = '0;
    out_word[0 +: INDEX_BITS]     = q4;
    out_word[OFF_C +: INDEX_BITS] = cand4;
    out_word[OFF_D +: DISTANCE_BITS] = best4;
  end

  nnrm_out_fifo #(
    .DATA_W (OUT_W)
  ) u_out_fifo (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .push_data     (out_word),
    .full          (fifo_full),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  `NNRM_ASSERT(a_count_sat, clk, rst, passed_count != 2'd3)
  `NNRM_ASSERT(a_query_clears, clk, rst, (adv && v2 && l2) |=> (passed_count == 2'd0))
  `NNRM_ASSERT(a_empty_no_match, clk, rst, (v4 && cnt4 == 2'd0) |-> !push)

endmodule

FILE: rtl/nnrm_gate.sv
// two-stage pass/fail gate on descriptor distance and image radius
// depends on nnrm_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nnrm_gate #(
  parameter int DISTANCE_BITS = nnrm_pkg::DISTANCE_BITS_DEF,
  parameter int COORD_BITS    = nnrm_pkg::COORD_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      adv,
  input  logic [DISTANCE_BITS-1:0]  pair_dist,
  input  logic [COORD_BITS-1:0]     query_u,
  input  logic [COORD_BITS-1:0]     query_v,
  input  logic [COORD_BITS-1:0]     cand_u,
  input  logic [COORD_BITS-1:0]     cand_v,
  input  nnrm_pkg::gate_cfg_t       cfg,
  output logic                      pass
);
  import nnrm_pkg::*;

  localparam int SQ_W   = 2 * COORD_BITS;
  localparam int SUM_W  = SQ_W + 1;
  localparam int R2_W   = 2 * RADIUS_W;
  localparam int CMP_W  = (SUM_W > R2_W) ? SUM_W : R2_W;
  localparam int DCMP_W = (DISTANCE_BITS > MAX_DIST_W) ? DISTANCE_BITS : MAX_DIST_W;

  logic [COORD_BITS-1:0] du;
  logic [COORD_BITS-1:0] dv;
  logic [SQ_W-1:0]       du2_next;
  logic [SQ_W-1:0]       dv2_next;
  logic [R2_W-1:0]       r2_next;
  logic                  dist_ok_next;

  logic [SQ_W-1:0]       du2;
  logic [SQ_W-1:0]       dv2;
  logic [R2_W-1:0]       r2;
  logic                  dist_ok;
  logic                  gate_on;
  logic [SUM_W-1:0]      sum;
  logic                  radius_ok;

  // absolute coordinate differences, squares and distance limit
  always_comb begin
    du           = (query_u >= cand_u) ? (query_u - cand_u) : (cand_u - query_u);
    dv           = (query_v >= cand_v) ? (query_v - cand_v) : (cand_v - query_v);
    du2_next     = {{COORD_BITS{1'b0}}, du} * {{COORD_BITS{1'b0}}, du};
    dv2_next     = {{COORD_BITS{1'b0}}, dv} * {{COORD_BITS{1'b0}}, dv};
    r2_next      = {{RADIUS_W{1'b0}}, cfg.max_image} * {{RADIUS_W{1'b0}}, cfg.max_image};
    dist_ok_next = !cfg.enforce_max ||
                   (DCMP_W'(pair_dist) < DCMP_W'(cfg.max_dist));
  end

  // first stage: squared terms
  always_ff @(posedge clk) begin
    if (adv) begin
      du2     <= du2_next;
      dv2     <= dv2_next;
      r2      <= r2_next;
      dist_ok <= dist_ok_next;
      gate_on <= cfg.gate_image;
    end
  end

  // squared radius compare
  always_comb begin
    sum       = {1'b0, du2} + {1'b0, dv2};
    radius_ok = !gate_on || (CMP_W'(sum) <= CMP_W'(r2));
  end

  // second stage: registered verdict
  always_ff @(posedge clk) begin
    if (adv) begin
      pass <= dist_ok && radius_ok;
    end
  end

  // a failing distance limit always fails the pair one stage later
  `NNRM_ASSERT_ALWAYS(a_dist_fail, clk, (adv && !dist_ok) |=> !pass)

endmodule

FILE: rtl/nnrm_out_fifo.sv
// two-entry result buffer: output register plus skid entry
// no package dependencies
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nnrm_out_fifo #(
  parameter int DATA_W = 48
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [DATA_W-1:0] m_axis_tdata
);

  logic [1:0]        count;
  logic [1:0]        count_next;
  logic [DATA_W-1:0] head;
  logic [DATA_W-1:0] tail;
  logic              pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign full          = (count == 2'd2);
  assign m_axis_tvalid = (count != 2'd0);
  assign m_axis_tdata  = head;

  // occupancy
  always_comb begin
    count_next = count + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  // entry data movement
  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) begin
        head <= tail;
      end else if (push) begin
        head <= push_data;
      end
    end else if (push) begin
      if (count == 2'd0) begin
        head <= push_data;
      end else begin
        tail <= push_data;
      end
    end
  end

  `NNRM_ASSERT(a_no_push_full, clk, rst, full |-> !push)
  `NNRM_ASSERT(a_count_range, clk, rst, count != 2'd3)

endmodule

FILE: verif/tb_nearest_neighbour_ratio_matcher_core.sv
// testbench for nearest_neighbour_ratio_matcher_core: directed and random candidate streams,
// every match checked against an in-bench best/second tracker with gating and ratio test
// depends on nnrm_pkg and the matcher rtl
`timescale 1ns / 1ps

module tb_nearest_neighbour_ratio_matcher_core;
  import nnrm_pkg::*;

  localparam int IDX_W  = INDEX_BITS_DEF;
  localparam int DIST_W = DISTANCE_BITS_DEF;
  localparam int CRD_W  = COORD_BITS_DEF;
  localparam int IN_W   = ((2 * IDX_W + DIST_W + 4 * CRD_W + 7) / 8) * 8;
  localparam int OUT_W  = ((2 * IDX_W + DIST_W + 7) / 8) * 8;

  // pipeline depth is 5, leave some margin before touching settings
  localparam int SETTLE_CYCLES = 12;
  localparam int LIMIT_CYCLES  = 200000;
  localparam int PHASE_PAIRS   = 94;

  // indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [IDX_W-1:0]  query;
    logic [IDX_W-1:0]  cand;
    logic [DIST_W-1:0] distance;
    logic [CRD_W-1:0]  qu;
    logic [CRD_W-1:0]  qv;
    logic [CRD_W-1:0]  cu;
    logic [CRD_W-1:0]  cv;
    logic              last;
  } pair_t;

  // ordered so that the low bits of m_axis_tdata map straight onto it
  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [IDX_W-1:0]  cand;
    logic [IDX_W-1:0]  query;
  } match_t;

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_wdata;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  // query_index, cand_index, descriptor_distance, query_u, query_v, cand_u, cand_v
  logic [IN_W-1:0]        s_axis_tdata;
  // last
  logic                   s_axis_tlast;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  // match_query, match_candidate, match_distance
  logic [OUT_W-1:0]       m_axis_tdata;

  // settings as the block should hold them
  logic                   set_enforce;
  logic [MAX_DIST_W-1:0]  set_max_dist;
  logic                   set_gate;
  logic [RADIUS_W-1:0]    set_radius;
  logic                   set_ratio_on;
  logic [RATIO_W-1:0]     set_ratio;

  // best and second-best tracker of the open query
  logic [DIST_W-1:0]      best_dist;
  logic [IDX_W-1:0]       best_cand;
  logic [DIST_W-1:0]      second_dist;
  logic [1:0]             passed;

  match_t expected_matches[$];
  int     mismatch_count = 0;
  int     cycle_count = 0;
  int     gap_pct = 0;
  int     stall_pct = 0;

  nearest_neighbour_ratio_matcher_core u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // gate one pair, update the tracker, and on last decide whether a match leaves
  function automatic void update_nearest(input pair_t p);
    logic [63:0] du;
    logic [63:0] dv;
    logic [63:0] reach;
    logic [63:0] scaled_best;
    logic [63:0] scaled_second;
    logic        ok;
    logic        accept;
    match_t      m;
    ok = 1'b1;
    if (set_enforce && !(p.distance < set_max_dist))
      ok = 1'b0;
    if (set_gate) begin
      du = {48'b0, ((p.qu >= p.cu) ? p.qu - p.cu : p.cu - p.qu)};
      dv = {48'b0, ((p.qv >= p.cv) ? p.qv - p.cv : p.cv - p.qv)};
      reach = {48'b0, set_radius};
      if (du * du + dv * dv > reach * reach)
        ok = 1'b0;
    end
    // rank the pair; ties leave the earlier one ahead
    if (ok) begin
      if (passed == 2'd0) begin
        best_dist = p.distance;
        best_cand = p.cand;
        passed    = 2'd1;
      end else begin
        if (p.distance < best_dist) begin
          second_dist = best_dist;
          best_dist   = p.distance;
          best_cand   = p.cand;
        end else if (passed == 2'd1 || p.distance < second_dist) begin
          second_dist = p.distance;
        end
        passed = 2'd2;
      end
    end
    if (p.last) begin
      scaled_best   = {40'b0, best_dist} << 16;
      scaled_second = {48'b0, set_ratio} * {40'b0, second_dist};
      accept = 1'b0;
      if (passed == 2'd1)
        accept = 1'b1;
      else if (passed == 2'd2)
        accept = !set_ratio_on || (scaled_best < scaled_second);
      if (accept) begin
        m.query    = p.query;
        m.cand     = best_cand;
        m.distance = best_dist;
        expected_matches = {expected_matches, m};
      end
      best_dist   = '0;
      best_cand   = '0;
      second_dist = '0;
      passed      = 2'd0;
    end
  endfunction

  // result side: random stalls and the match check
  always @(posedge clk) begin : take_match
    match_t got;
    match_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[2 * IDX_W + DIST_W - 1:0];
      if (expected_matches.size() == 0) begin
        mismatch_count++;
        $display("%0t ns: match with none expected, got query %h cand %h distance %h",
                 $time, got.query, got.cand, got.distance);
      end else begin
        want = expected_matches.pop_front();
        if (got.query !== want.query || got.cand !== want.cand ||
            got.distance !== want.distance) begin
          mismatch_count++;
          $display({"%0t ns: match mismatch, expected query %h cand %h distance %h,",
                    " got query %h cand %h distance %h"}, $time, want.query, want.cand,
                   want.distance, got.query, got.cand, got.distance);
        end
      end
    end
    m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  // one pair transfer, with optional idle cycles ahead of it
  task automatic send_pair(input pair_t p);
    while ($urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.cv, p.cu, p.qv, p.qu, p.distance, p.cand, p.query};
    s_axis_tlast  <= p.last;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    update_nearest(p);
  endtask

  function automatic pair_t make_pair(input logic [IDX_W-1:0] q, input logic [IDX_W-1:0] c,
                                      input logic [DIST_W-1:0] d,
                                      input logic [CRD_W-1:0] qu, input logic [CRD_W-1:0] qv,
                                      input logic [CRD_W-1:0] cu, input logic [CRD_W-1:0] cv,
                                      input logic last);
    pair_t p;
    p.query    = q;
    p.cand     = c;
    p.distance = d;
    p.qu       = qu;
    p.qv       = qv;
    p.cu       = cu;
    p.cv       = cv;
    p.last     = last;
    return p;
  endfunction

  // setting write, mirrored into the tracker settings
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    case (idx)
      CFG_ENFORCE_MAX_DISTANCE:    set_enforce  = value[0];
      CFG_MAX_DESCRIPTOR_DISTANCE: set_max_dist = value[MAX_DIST_W-1:0];
      CFG_GATE_IMAGE_DISTANCE:     set_gate     = value[0];
      CFG_MAX_IMAGE_DISTANCE:      set_radius   = value[RADIUS_W-1:0];
      CFG_USE_RATIO_TEST:          set_ratio_on = value[0];
      CFG_RATIO:                   set_ratio    = value[RATIO_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop sending, wait for every match, then let pairs with no result drain
  task automatic settle_matcher();
    s_axis_tvalid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // reset settings: single survivor, ties, extreme fields, query index drift
  task automatic test_default_settings();
    send_pair(make_pair(0, 0, 0, 0, 0, 0, 0, 1));
    send_pair(make_pair('hFFF, 'hFFF, 'hFFFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 0));
    send_pair(make_pair('h5A5, 'h123, 'hFFFFFF, 0, 0, 0, 0, 1));
    send_pair(make_pair('h001, 'h010, 30, 0, 0, 0, 0, 0));
    send_pair(make_pair('h002, 'h020, 10, 0, 0, 0, 0, 0));
    send_pair(make_pair('h007, 'h030, 20, 0, 0, 0, 0, 1));
    settle_matcher();
  endtask

  // descriptor limit is strict, including the zero and full limits
  task automatic test_distance_limit();
    write_reg(CFG_ENFORCE_MAX_DISTANCE, 1);
    write_reg(CFG_MAX_DESCRIPTOR_DISTANCE, 100);
    send_pair(make_pair('h101, 'h001, 100, 0, 0, 0, 0, 1));
    send_pair(make_pair('h102, 'h002, 99, 0, 0, 0, 0, 0));
    send_pair(make_pair('h102, 'h003, 100, 0, 0, 0, 0, 1));
    settle_matcher();
    write_reg(CFG_MAX_DESCRIPTOR_DISTANCE, 0);
    send_pair(make_pair('h103, 'h004, 0, 0, 0, 0, 0, 1));
    settle_matcher();
    write_reg(CFG_MAX_DESCRIPTOR_DISTANCE, 'hFFFFFF);
    send_pair(make_pair('h104, 'h005, 'hFFFFFF, 0, 0, 0, 0, 0));
    send_pair(make_pair('h104, 'h006, 'hFFFFFE, 0, 0, 0, 0, 1));
    settle_matcher();
    write_reg(CFG_ENFORCE_MAX_DISTANCE, 0);
  endtask

  // radius gate: exactly on the circle passes, one step outside fails
  task automatic test_image_radius();
    write_reg(CFG_GATE_IMAGE_DISTANCE, 1);
    write_reg(CFG_MAX_IMAGE_DISTANCE, 160);
    send_pair(make_pair('h201, 'h001, 50, 1000, 1000, 1160, 1000, 1));
    send_pair(make_pair('h202, 'h002, 10, 1000, 1000, 903, 1128, 0));
    send_pair(make_pair('h202, 'h003, 40, 1000, 1000, 1096, 872, 1));
    settle_matcher();
    write_reg(CFG_MAX_IMAGE_DISTANCE, 0);
    send_pair(make_pair('h203, 'h004, 5, 500, 600, 500, 600, 1));
    send_pair(make_pair('h204, 'h005, 5, 500, 600, 501, 600, 1));
    settle_matcher();
    write_reg(CFG_MAX_IMAGE_DISTANCE, 'hFFFF);
    send_pair(make_pair('h205, 'h006, 7, 0, 0, 'hFFFF, 0, 1));
    send_pair(make_pair('h206, 'h007, 7, 0, 0, 'hFFFF, 1, 1));
    settle_matcher();
    write_reg(CFG_GATE_IMAGE_DISTANCE, 0);
  endtask

  // ratio test at the default, zero and full ratio, plus a lone survivor
  task automatic test_ratio_test();
    write_reg(CFG_USE_RATIO_TEST, 1);
    send_pair(make_pair('h301, 'h001, 80, 0, 0, 0, 0, 0));
    send_pair(make_pair('h301, 'h002, 100, 0, 0, 0, 0, 1));
    settle_matcher();
    write_reg(CFG_RATIO, 0);
    send_pair(make_pair('h302, 'h003, 0, 0, 0, 0, 0, 0));
    send_pair(make_pair('h302, 'h004, 0, 0, 0, 0, 0, 1));
    settle_matcher();
    write_reg(CFG_RATIO, 'hFFFF);
    send_pair(make_pair('h303, 'h005, 65535, 0, 0, 0, 0, 0));
    send_pair(make_pair('h303, 'h006, 65534, 0, 0, 0, 0, 1));
    send_pair(make_pair('h304, 'h007, 12345, 0, 0, 0, 0, 1));
    settle_matcher();
  endtask

  // coordinate near another one, now and then anywhere
  function automatic logic [CRD_W-1:0] near_coord(input logic [CRD_W-1:0] c);
    int v;
    if ($urandom_range(0, 9) == 0)
      return CRD_W'($urandom());
    v = int'(c);
    v = v - 2500 + int'($urandom_range(0, 5000));
    if (v < 0)
      v = 0;
    if (v > 65535)
      v = 65535;
    return CRD_W'(v);
  endfunction

  // a well-formed query: candidates around the query point, last on the final one
  task automatic send_query(inout int sent);
    pair_t p;
    int    k;
    int    spread;
    k = ($urandom_range(0, 9) == 0) ? int'($urandom_range(7, 12))
                                    : int'($urandom_range(1, 6));
    spread = int'($urandom_range(0, 3));
    p.query = IDX_W'($urandom());
    p.qu    = CRD_W'($urandom());
    p.qv    = CRD_W'($urandom());
    for (int i = 0; i < k; i++) begin
      p.cand = IDX_W'($urandom());
      case (spread)
        0:       p.distance = DIST_W'($urandom_range(0, 7));
        3:       p.distance = DIST_W'($urandom());
        default: p.distance = DIST_W'($urandom_range(0, 4095));
      endcase
      p.cu = near_coord(p.qu);
      p.cv = near_coord(p.qv);
      if ($urandom_range(0, 19) == 0)
        p.query = IDX_W'($urandom());
      p.last = (i == k - 1);
      send_pair(p);
      sent++;
    end
  endtask

  // noise: fully random pairs with stray last flags, closed by a last
  task automatic send_noise(inout int sent);
    pair_t p;
    int    k;
    k = int'($urandom_range(1, 4));
    for (int i = 0; i < k; i++) begin
      p.query    = IDX_W'($urandom());
      p.cand     = IDX_W'($urandom());
      p.distance = DIST_W'($urandom());
      p.qu       = CRD_W'($urandom());
      p.qv       = CRD_W'($urandom());
      p.cu       = CRD_W'($urandom());
      p.cv       = CRD_W'($urandom());
      p.last     = (i == k - 1) || ($urandom_range(0, 2) == 0);
      send_pair(p);
      sent++;
    end
  endtask

  // fresh settings for a random phase, junk in the unused upper bits
  task automatic pick_settings(input int phase);
    logic [CFG_DATA_W-1:0] junk;
    logic [MAX_DIST_W-1:0] limit;
    logic [RADIUS_W-1:0]   radius;
    logic [RATIO_W-1:0]    ratio;
    logic                  enforce;
    logic                  gate;
    logic                  ratio_on;
    junk     = CFG_DATA_W'($urandom());
    enforce  = (phase != 0) && ($urandom_range(0, 1) == 1);
    gate     = (phase != 0) && ($urandom_range(0, 1) == 1);
    ratio_on = (phase != 0) && ($urandom_range(0, 2) != 0);
    case ($urandom_range(0, 3))
      0:       limit = '0;
      1:       limit = '1;
      default: limit = MAX_DIST_W'($urandom_range(0, 5000));
    endcase
    case ($urandom_range(0, 3))
      0:       radius = '0;
      1:       radius = '1;
      default: radius = RADIUS_W'($urandom_range(0, 3000));
    endcase
    case ($urandom_range(0, 3))
      0:       ratio = '0;
      1:       ratio = '1;
      default: ratio = RATIO_W'($urandom_range(20000, 65535));
    endcase
    write_reg(CFG_ENFORCE_MAX_DISTANCE, {junk[23:1], enforce});
    write_reg(CFG_MAX_DESCRIPTOR_DISTANCE, limit);
    write_reg(CFG_GATE_IMAGE_DISTANCE, {junk[23:1], gate});
    write_reg(CFG_MAX_IMAGE_DISTANCE, {junk[7:0], radius});
    write_reg(CFG_USE_RATIO_TEST, {junk[23:1], ratio_on});
    write_reg(CFG_RATIO, {junk[7:0], ratio});
    // writes to unused indexes must change nothing
    write_reg(phase[0] ? CFG_SPARE_HI : CFG_SPARE_LO, CFG_DATA_W'($urandom()));
  endtask

  // random phases over every idle pattern, with a full drain halfway through each
  task automatic test_random_traffic();
    int sent;
    bit drained;
    for (int phase = 0; phase < 8; phase++) begin
      settle_matcher();
      gap_pct   = (phase % 4 == 1) ? 65 : (phase % 4 == 3) ? 16 : 0;
      stall_pct = (phase % 4 == 2) ? 65 : (phase % 4 == 3) ? 16 : 0;
      pick_settings(phase);
      sent    = 0;
      drained = 1'b0;
      while (sent < PHASE_PAIRS) begin
        if (!drained && sent >= PHASE_PAIRS / 2) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk);
          while (expected_matches.size() != 0) @(posedge clk);
          drained = 1'b1;
        end
        if ($urandom_range(0, 9) < 8)
          send_query(sent);
        else
          send_noise(sent);
      end
    end
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  initial begin
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_ENFORCE_MAX_DISTANCE;
    cfg_wdata     <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tlast  <= 1'b0;
    set_enforce  = 1'b0;
    set_max_dist = MAX_DIST_RESET;
    set_gate     = 1'b0;
    set_radius   = RADIUS_RESET;
    set_ratio_on = 1'b0;
    set_ratio    = RATIO_RESET;
    best_dist    = '0;
    best_cand    = '0;
    second_dist  = '0;
    passed       = 2'd0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_default_settings();
    test_distance_limit();
    test_image_radius();
    test_ratio_test();
    test_random_traffic();
    settle_matcher();

    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

FILE: nearest_neighbour_ratio_matcher_core.f
+incdir+rtl
rtl/nnrm_pkg.sv
rtl/nnrm_gate.sv
rtl/nnrm_out_fifo.sv
rtl/nearest_neighbour_ratio_matcher_core.sv
verif/tb_nearest_neighbour_ratio_matcher_core.sv
